>>> rtl/char_lcd_nibble_writer_macros.svh
// Assertion helpers shared by the RTL files.
// Each check is sampled on the rising clock and held off while reset is active.
`ifndef CHAR_LCD_NIBBLE_WRITER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/clcd_pkg.sv
`default_nettype none

package clcd_pkg;

	// Operation codes carried in the input tuser.
	localparam logic [2:0] MODE_CMD    = 3'd0;
	localparam logic [2:0] MODE_CHAR   = 3'd1;
	localparam logic [2:0] MODE_STRING = 3'd2;
	localparam logic [2:0] MODE_INIT   = 3'd3;
	localparam logic [2:0] MODE_GOTO   = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ENABLE_PULSE = 2'd0;
	localparam logic [1:0] CFG_POWER_UP     = 2'd1;
	localparam logic [1:0] CFG_INIT_STEP    = 2'd2;
	localparam logic [1:0] CFG_ROW_LENGTH   = 2'd3;

	// Register reset values.
	localparam logic [15:0] POWER_UP_WAIT_RST = 16'd20000;
	localparam logic [15:0] INIT_STEP_WAIT_RST = 16'd5000;
	localparam logic [5:0]  ROW_LENGTH_RST = 6'd16;

	// Controller opcodes.
	localparam logic [7:0] OP_WAKE_8BIT    = 8'h33;
	localparam logic [7:0] OP_WAKE_4BIT    = 8'h32;
	localparam logic [7:0] OP_FUNC_4BIT_2L = 8'h28;
	localparam logic [7:0] OP_DISPLAY_ON   = 8'h0C;
	localparam logic [7:0] OP_ENTRY_INC    = 8'h06;
	localparam logic [7:0] OP_CLEAR        = 8'h01;
	localparam logic [7:0] OP_ROW0_BASE    = 8'h80;
	localparam logic [7:0] OP_ROW1_BASE    = 8'hC0;

	// What the back end has to send for one queued request.
	typedef enum logic [1:0] {
		JOB_BYTE,
		JOB_BYTE_ROW1,
		JOB_BYTE_CLEAR,
		JOB_INIT
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] data;
		logic       rs;
	} job_t;

	// One byte of a job with its register select and its lead-in wait.
	typedef struct packed {
		logic [7:0]  value;
		logic        rs;
		logic [15:0] wait_us;
	} xfer_byte_t;

	// Index of the final byte of a job.
	function automatic logic [2:0] job_last_idx(job_kind_t kind);
		logic [2:0] r;
		case (kind)
			JOB_BYTE:       r = 3'd0;
			JOB_BYTE_ROW1:  r = 3'd1;
			JOB_BYTE_CLEAR: r = 3'd2;
			JOB_INIT:       r = 3'd5;
			default:        r = 3'd0;
		endcase
		return r;
	endfunction

	// Byte number idx of a job.
	function automatic xfer_byte_t job_byte(job_t j, logic [2:0] idx,
			logic [15:0] power_up_wait, logic [15:0] init_step_wait);
		xfer_byte_t b;
		b.value = j.data;
		b.rs = 1'b0;
		b.wait_us = '0;
		if (j.kind == JOB_INIT) begin
			case (idx)
				3'd0: begin
					b.value = OP_WAKE_8BIT;
					b.wait_us = power_up_wait;
				end
				3'd1: begin
					b.value = OP_WAKE_4BIT;
					b.wait_us = init_step_wait;
				end
				3'd2: begin
					b.value = OP_FUNC_4BIT_2L;
					b.wait_us = init_step_wait;
				end
				3'd3: b.value = OP_DISPLAY_ON;
				3'd4: b.value = OP_ENTRY_INC;
				default: b.value = OP_CLEAR;
			endcase
		end else begin
			case (idx)
				3'd0: begin
					b.value = j.data;
					b.rs = j.rs;
				end
				3'd1: b.value = (j.kind == JOB_BYTE_ROW1) ? OP_ROW1_BASE : OP_CLEAR;
				default: b.value = OP_ROW0_BASE;
			endcase
		end
		return b;
	endfunction

endpackage

`default_nettype wire

>>> rtl/clcd_front.sv
`default_nettype none

module clcd_front import clcd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] mode,
	input  wire logic [7:0] data_byte,
	input  wire logic       string_first,
	input  wire logic [1:0] row,
	input  wire logic [5:0] column,
	input  wire logic [5:0] row_length,
	input  wire logic       q_full,
	output logic            push,
	output job_t            job
);

	logic [6:0] count_q;
	logic [6:0] count_base;
	logic [6:0] count_inc;
	logic [6:0] count_d;
	logic       accept;
	logic       emits;
	logic       wrap_row;
	logic       wrap_clear;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	// String counting: restart, bump, and check for the two wrap points.
	always_comb begin
		count_base = string_first ? 7'd0 : count_q;
		count_inc = count_base + 7'd1;
		wrap_row = (row_length != 6'd0) && (count_inc == {1'b0, row_length});
		wrap_clear = (row_length != 6'd0) && (count_inc == {row_length, 1'b0});
		if (data_byte == 8'd0) begin
			count_d = count_base;
		end else if (wrap_clear) begin
			count_d = 7'd0;
		end else begin
			count_d = count_inc;
		end
	end

	// Turn the request into a job for the back end.
	always_comb begin
		emits = 1'b0;
		job.kind = JOB_BYTE;
		job.data = data_byte;
		job.rs = 1'b0;
		case (mode)
			MODE_CMD: emits = 1'b1;
			MODE_CHAR: begin
				emits = 1'b1;
				job.rs = 1'b1;
			end
			MODE_STRING: begin
				emits = (data_byte != 8'd0);
				job.rs = 1'b1;
				if (wrap_clear) begin
					job.kind = JOB_BYTE_CLEAR;
				end else if (wrap_row) begin
					job.kind = JOB_BYTE_ROW1;
				end
			end
			MODE_INIT: begin
				emits = 1'b1;
				job.kind = JOB_INIT;
			end
			MODE_GOTO: begin
				emits = !row[1];
				job.data = (row[0] ? OP_ROW1_BASE : OP_ROW0_BASE) + {2'b00, column};
			end
			default: emits = 1'b0;
		endcase
	end

	assign push = accept && emits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && (mode == MODE_STRING)) begin
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/clcd_queue.sv
`default_nettype none
`include "char_lcd_nibble_writer_macros.svh"

module clcd_queue import clcd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire job_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output job_t      rd_data,
	output logic      empty
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	// Two-entry job store.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_queue_level, clk, arst_n, count_q <= 2'd2, "queue level above two")
	`ASSERT_IMPLY(a_queue_no_pop_empty, clk, arst_n, rd_en, !empty, "pop from empty queue")
	`ASSERT_IMPLY(a_queue_ptrs, clk, arst_n, count_q == 2'd0 || count_q == 2'd2,
		wr_ptr_q == rd_ptr_q, "queue pointers disagree with level")

endmodule

`default_nettype wire

>>> rtl/clcd_back.sv
`default_nettype none
`include "char_lcd_nibble_writer_macros.svh"

module clcd_back import clcd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire job_t        job,
	input  wire logic        job_valid,
	output logic             pop,
	input  wire logic [15:0] power_up_wait,
	input  wire logic [15:0] init_step_wait,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       out_nibble,
	output logic             out_rs,
	output logic [15:0]      out_wait,
	output logic             out_last
);

	logic [2:0] idx_q;
	logic       phase_q;
	logic       out_valid_q;
	logic [3:0] nibble_q;
	logic       rs_q;
	logic [15:0] wait_q;
	logic       last_q;
	xfer_byte_t cur;
	logic       load;
	logic       last_byte;
	logic       last_xfer;

	// Pick the current byte and nibble of the head job.
	always_comb begin
		cur = job_byte(job, idx_q, power_up_wait, init_step_wait);
		last_byte = (idx_q == job_last_idx(job.kind));
		last_xfer = phase_q && last_byte;
		load = job_valid && (!out_valid_q || out_ready);
		pop = load && last_xfer;
	end

	// Byte and nibble position within the job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			phase_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q <= !phase_q;
				if (phase_q) begin
					idx_q <= last_byte ? 3'd0 : idx_q + 3'd1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register holding one transfer request.
	always_ff @(posedge clk) begin
		if (load) begin
			nibble_q <= phase_q ? cur.value[3:0] : cur.value[7:4];
			rs_q <= cur.rs;
			wait_q <= phase_q ? 16'd0 : cur.wait_us;
			last_q <= last_xfer;
		end
	end

	assign out_valid = out_valid_q;
	assign out_nibble = nibble_q;
	assign out_rs = rs_q;
	assign out_wait = wait_q;
	assign out_last = last_q;

	`ASSERT_IMPLY(a_back_idx_range, clk, arst_n, job_valid,
		idx_q <= job_last_idx(job.kind), "byte index past end of job")
	`ASSERT_IMPLY(a_back_phase_job, clk, arst_n, phase_q, job_valid,
		"low nibble pending without a job")
	`ASSERT_IMPLY(a_back_idle_pos, clk, arst_n, !job_valid,
		idx_q == 3'd0 && !phase_q, "position not cleared between jobs")

endmodule

`default_nettype wire

>>> rtl/char_lcd_nibble_writer.sv
`default_nettype none

// Character LCD nibble writer for a 4-bit HD44780-style bus. Each input request
// (tuser = mode) is a command byte, a character, a counted string character, the
// power-up sequence, or a cursor move; every byte leaves as two transfer requests,
// high nibble first, each with its lead-in wait in microseconds, and tlast marks the
// final transfer of a request. The back end emits one transfer per clock while a job
// is queued and the receiver is ready: 2 transfers for a plain byte, 4 or 6 for a
// string character that wraps the row or clears the screen, 12 for the init sequence.
// A two-entry job queue sits between the request decoder and the transfer sequencer,
// so new requests are taken while earlier ones are still being sent. Requests that
// send nothing (string terminator, goto to row 2 or 3, unused modes) are accepted
// without queueing a job. The enable pulse width register is accepted but does not
// affect any transfer request; the pin driver applies its own pulse timing.
module char_lcd_nibble_writer import clcd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// data_byte[7:0], string_first[8], row[10:9], column[16:11], zero[23:17]
	input  wire logic [23:0] s_axis_tdata,
	// mode[2:0]
	input  wire logic [2:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// nibble[3:0], wait_before_us[19:4], zero[23:20]
	output logic [23:0]      m_axis_tdata,
	// reg_select[0]
	output logic             m_axis_tuser,
	output logic             m_axis_tlast,
	input  wire logic        cfg_wen,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	logic [15:0] power_up_wait_q;
	logic [15:0] init_step_wait_q;
	logic [5:0]  row_length_q;
	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_empty;
	job_t        wr_job;
	job_t        head_job;
	logic [3:0]  out_nibble;
	logic [15:0] out_wait;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_up_wait_q <= POWER_UP_WAIT_RST;
			init_step_wait_q <= INIT_STEP_WAIT_RST;
			row_length_q <= ROW_LENGTH_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_POWER_UP:   power_up_wait_q <= cfg_wdata;
				CFG_INIT_STEP:  init_step_wait_q <= cfg_wdata;
				CFG_ROW_LENGTH: row_length_q <= cfg_wdata[5:0];
				default:        power_up_wait_q <= power_up_wait_q;
			endcase
		end
	end

	clcd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.mode         (s_axis_tuser),
		.data_byte    (s_axis_tdata[7:0]),
		.string_first (s_axis_tdata[8]),
		.row          (s_axis_tdata[10:9]),
		.column       (s_axis_tdata[16:11]),
		.row_length   (row_length_q),
		.q_full       (q_full),
		.push         (push),
		.job          (wr_job)
	);

	clcd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (wr_job),
		.full    (q_full),
		.rd_en   (pop),
		.rd_data (head_job),
		.empty   (q_empty)
	);

	clcd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job            (head_job),
		.job_valid      (!q_empty),
		.pop            (pop),
		.power_up_wait  (power_up_wait_q),
		.init_step_wait (init_step_wait_q),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_nibble     (out_nibble),
		.out_rs         (m_axis_tuser),
		.out_wait       (out_wait),
		.out_last       (m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, out_wait, out_nibble};

endmodule

`default_nettype wire

>>> test/char_lcd_nibble_writer_tb.sv
module char_lcd_nibble_writer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import clcd_pkg::*;

	localparam int DRAIN_CYCLES = 24;
	localparam int WATCHDOG_LIMIT = 2000;

	// One LCD request as it enters the block.
	typedef struct {
		logic [2:0] mode;
		logic [7:0] data;
		logic       first;
		logic [1:0] row;
		logic [5:0] col;
	} lcd_req_t;

	// One byte bound for the display, before it is split into nibbles.
	typedef struct {
		logic [7:0]  value;
		logic        rs;
		logic [15:0] wait_us;
	} lcd_byte_t;

	// One nibble transfer as it leaves the block.
	typedef struct {
		logic [3:0]  nibble;
		logic        rs;
		logic [15:0] wait_us;
		logic        last;
	} lcd_xfer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	lcd_req_t  request_q[$];
	lcd_xfer_t transfer_q[$];
	lcd_req_t  drv_req;
	lcd_req_t  mon_req;
	lcd_xfer_t want;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_send = 1'b0;
	int err_count = 0;
	int stall_cycles = 0;

	// Shadow copy of the block's registers and string counter.
	logic [15:0] enable_pulse_us;
	logic [15:0] power_up_wait_us;
	logic [15:0] init_step_wait_us;
	logic [5:0]  row_len = ROW_LENGTH_RST;
	logic [6:0]  str_count;

	char_lcd_nibble_writer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Work out the nibble transfers that one accepted request causes.
	task automatic predict_transfers(input lcd_req_t rq);
		lcd_byte_t seq[$];
		lcd_xfer_t x;
		int k;
		case (rq.mode)
			MODE_CMD: seq.push_back('{rq.data, 1'b0, 16'd0});
			MODE_CHAR: seq.push_back('{rq.data, 1'b1, 16'd0});
			MODE_STRING: begin
				if (rq.first)
					str_count = '0;
				if (rq.data != 8'd0) begin
					str_count = str_count + 7'd1;
					seq.push_back('{rq.data, 1'b1, 16'd0});
					if (row_len != 6'd0) begin
						if (str_count == {1'b0, row_len})
							seq.push_back('{OP_ROW1_BASE, 1'b0, 16'd0});
						if (int'(str_count) == 2 * int'(row_len)) begin
							seq.push_back('{OP_CLEAR, 1'b0, 16'd0});
							seq.push_back('{OP_ROW0_BASE, 1'b0, 16'd0});
							str_count = '0;
						end
					end
				end
			end
			MODE_INIT: begin
				seq.push_back('{OP_WAKE_8BIT, 1'b0, power_up_wait_us});
				seq.push_back('{OP_WAKE_4BIT, 1'b0, init_step_wait_us});
				seq.push_back('{OP_FUNC_4BIT_2L, 1'b0, init_step_wait_us});
				seq.push_back('{OP_DISPLAY_ON, 1'b0, 16'd0});
				seq.push_back('{OP_ENTRY_INC, 1'b0, 16'd0});
				seq.push_back('{OP_CLEAR, 1'b0, 16'd0});
			end
			MODE_GOTO: begin
				if (rq.row == 2'd0)
					seq.push_back('{OP_ROW0_BASE + {2'b00, rq.col}, 1'b0, 16'd0});
				else if (rq.row == 2'd1)
					seq.push_back('{OP_ROW1_BASE + {2'b00, rq.col}, 1'b0, 16'd0});
			end
			default: ;
		endcase
		// High nibble carries the wait, the low nibble of the final byte ends the request.
		for (k = 0; k < seq.size(); k++) begin
			x = '{seq[k].value[7:4], seq[k].rs, seq[k].wait_us, 1'b0};
			transfer_q.push_back(x);
			x = '{seq[k].value[3:0], seq[k].rs, 16'd0, k == seq.size() - 1};
			transfer_q.push_back(x);
		end
	endtask

	function automatic bit sends_something(input lcd_req_t rq);
		if (rq.mode == MODE_STRING)
			return rq.data != 8'd0;
		if (rq.mode == MODE_GOTO)
			return !rq.row[1];
		return rq.mode <= MODE_GOTO;
	endfunction

	function automatic lcd_req_t random_req();
		lcd_req_t rq;
		rq.mode = 3'($urandom_range(0, 7));
		rq.data = 8'($urandom_range(0, 255));
		rq.first = 1'($urandom_range(0, 1));
		rq.row = 2'($urandom_range(0, 3));
		rq.col = 6'($urandom_range(0, 63));
		return rq;
	endfunction

	task automatic add_req(input logic [2:0] mode, input logic [7:0] data, input logic first,
			input logic [1:0] row, input logic [5:0] col);
		lcd_req_t rq;
		rq = '{mode, data, first, row, col};
		request_q.push_back(rq);
	endtask

	// Mostly whole strings with random text, the rest single requests of any kind.
	task automatic queue_random(input int target);
		lcd_req_t rq;
		int credited;
		int burst;
		int i;
		credited = 0;
		while (credited < target) begin
			if ($urandom_range(0, 99) < 55) begin
				burst = (row_len == 6'd0) ? $urandom_range(1, 140)
					: $urandom_range(1, 2 * int'(row_len) + 2);
				for (i = 0; i < burst && credited < target; i++) begin
					rq = random_req();
					rq.mode = MODE_STRING;
					rq.data = 8'($urandom_range(1, 255));
					rq.first = (i == 0) && ($urandom_range(0, 9) != 0);
					request_q.push_back(rq);
					credited++;
				end
				if ($urandom_range(0, 1) == 1) begin
					rq = random_req();
					rq.mode = MODE_STRING;
					rq.data = 8'd0;
					request_q.push_back(rq);
				end
			end else begin
				rq = random_req();
				request_q.push_back(rq);
				if (sends_something(rq))
					credited++;
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (request_q.size() != 0 || s_axis_tvalid || transfer_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Request driver: presents the next pending request once the previous one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (request_q.size() != 0 && !hold_send &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				drv_req = request_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {7'd0, drv_req.col, drv_req.row, drv_req.first, drv_req.data};
				s_axis_tuser <= drv_req.mode;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Transfer sink with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Monitor: tracks register writes, predicts from accepted requests, checks transfers.
	always @(posedge clk) begin
		if (!arst_n) begin
			enable_pulse_us = 16'd5000;
			power_up_wait_us = POWER_UP_WAIT_RST;
			init_step_wait_us = INIT_STEP_WAIT_RST;
			row_len = ROW_LENGTH_RST;
			str_count = '0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					CFG_ENABLE_PULSE: enable_pulse_us = cfg_wdata;
					CFG_POWER_UP: power_up_wait_us = cfg_wdata;
					CFG_INIT_STEP: init_step_wait_us = cfg_wdata;
					CFG_ROW_LENGTH: row_len = cfg_wdata[5:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				mon_req.mode = s_axis_tuser;
				mon_req.data = s_axis_tdata[7:0];
				mon_req.first = s_axis_tdata[8];
				mon_req.row = s_axis_tdata[10:9];
				mon_req.col = s_axis_tdata[16:11];
				predict_transfers(mon_req);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (transfer_q.size() == 0) begin
					$error("unexpected transfer: nibble %0h rs %0b wait %0d last %0b",
						m_axis_tdata[3:0], m_axis_tuser, m_axis_tdata[19:4], m_axis_tlast);
					err_count++;
				end else begin
					want = transfer_q.pop_front();
					if (m_axis_tdata[3:0] !== want.nibble) begin
						$error("nibble: expected %0h, got %0h", want.nibble, m_axis_tdata[3:0]);
						err_count++;
					end
					if (m_axis_tuser !== want.rs) begin
						$error("reg_select: expected %0b, got %0b", want.rs, m_axis_tuser);
						err_count++;
					end
					if (m_axis_tdata[19:4] !== want.wait_us) begin
						$error("wait_before_us: expected %0d, got %0d", want.wait_us,
							m_axis_tdata[19:4]);
						err_count++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, m_axis_tlast);
						err_count++;
					end
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves a request.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("char_lcd_nibble_writer_tb: FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		// Directed requests at the reset settings.
		add_req(MODE_INIT, 8'h00, 1'b0, 2'd0, 6'd0);
		add_req(MODE_CMD, 8'h00, 1'b0, 2'd0, 6'd0);
		add_req(MODE_CMD, 8'hFF, 1'b1, 2'd3, 6'd63);
		add_req(MODE_CHAR, 8'h5A, 1'b0, 2'd1, 6'd21);
		add_req(MODE_CHAR, 8'hA5, 1'b1, 2'd2, 6'd42);
		add_req(MODE_GOTO, 8'h00, 1'b0, 2'd0, 6'd0);
		add_req(MODE_GOTO, 8'hFF, 1'b1, 2'd1, 6'd63);
		add_req(MODE_GOTO, 8'h00, 1'b0, 2'd0, 6'd63);
		add_req(MODE_GOTO, 8'h11, 1'b0, 2'd1, 6'd0);
		// Goto to row 2 or 3 sends nothing.
		add_req(MODE_GOTO, 8'h00, 1'b0, 2'd2, 6'd21);
		add_req(MODE_GOTO, 8'hFF, 1'b1, 2'd3, 6'd63);
		// Unused modes are dropped.
		add_req(3'd5, 8'hFF, 1'b1, 2'd3, 6'd63);
		add_req(3'd6, 8'h3C, 1'b0, 2'd1, 6'd5);
		add_req(3'd7, 8'h00, 1'b1, 2'd0, 6'd40);
		// String characters, including the terminator with and without a restart.
		add_req(MODE_STRING, 8'hFF, 1'b1, 2'd0, 6'd0);
		add_req(MODE_STRING, 8'h01, 1'b0, 2'd3, 6'd63);
		add_req(MODE_STRING, 8'h00, 1'b1, 2'd0, 6'd0);
		add_req(MODE_STRING, 8'h00, 1'b0, 2'd0, 6'd0);
		add_req(MODE_STRING, 8'h41, 1'b0, 2'd1, 6'd1);
		queue_random(45);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		wait_drained();

		// Shortest rows and extreme waits; the sender also holds off once.
		write_reg(CFG_ENABLE_PULSE, 16'd1);
		write_reg(CFG_POWER_UP, 16'd0);
		write_reg(CFG_INIT_STEP, 16'hFFFF);
		write_reg(CFG_ROW_LENGTH, 16'd1);
		set_idling(66, 0);
		queue_random(60);
		do
			@(negedge clk);
		while (request_q.size() > 30);
		hold_send = 1'b1;
		do
			@(negedge clk);
		while (s_axis_tvalid || transfer_q.size() != 0);
		repeat (5) @(negedge clk);
		hold_send = 1'b0;
		wait_drained();

		// Forty-character rows with the waits the other way round.
		write_reg(CFG_ENABLE_PULSE, 16'hFFFF);
		write_reg(CFG_POWER_UP, 16'hFFFF);
		write_reg(CFG_INIT_STEP, 16'd0);
		write_reg(CFG_ROW_LENGTH, 16'd40);
		set_idling(0, 66);
		queue_random(60);
		wait_drained();

		// Row length zero never wraps; upper data bits must be dropped.
		write_reg(CFG_ENABLE_PULSE, 16'($urandom_range(1, 65535)));
		write_reg(CFG_POWER_UP, 16'($urandom_range(0, 65535)));
		write_reg(CFG_INIT_STEP, 16'($urandom_range(0, 65535)));
		write_reg(CFG_ROW_LENGTH, 16'hFFC0);
		set_idling(26, 26);
		queue_random(70);
		wait_drained();

		// Widest row field, so the clear comes just before the counter wraps.
		write_reg(CFG_ROW_LENGTH, 16'h7FFF);
		write_reg(CFG_POWER_UP, 16'h5555);
		set_idling(0, 0);
		queue_random(60);
		wait_drained();

		write_reg(CFG_ROW_LENGTH, 16'd2);
		write_reg(CFG_INIT_STEP, 16'hAAAA);
		set_idling(66, 66);
		queue_random(60);
		wait_drained();

		if (err_count == 0)
			$display("char_lcd_nibble_writer_tb: PASS");
		else
			$display("char_lcd_nibble_writer_tb: FAIL");
		$finish;
	end

endmodule
